// ===== rtl/core/lphash_pkg.sv =====
// Shared types and constants for the linear probing hash table.
// No dependencies; lphash_mod and the top level import this package.
`default_nettype none

package lphash_pkg;

  localparam int CFG_W           = 9;
  localparam int OP_W            = 2;
  localparam int KEY_W           = 32;
  localparam int DATA_W          = 32;
  localparam int TABLE_DEPTH_DEF = 256;

  localparam logic [CFG_W-1:0] CFG_SIZE_RESET = CFG_W'(256);

  localparam logic [OP_W-1:0] OP_SEARCH = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  // One table slot as it is stored in memory.
  typedef struct packed {
    logic              used;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] value;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CLEAR = 5'b00010,
    ST_HASH  = 5'b00100,
    ST_PROBE = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/lphash_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module lphash_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] waddr,
  input  wire  [WIDTH-1:0]         wdata,
  input  wire  [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/lphash_mod.sv =====
// Bit-serial remainder unit: key modulo the slot count, one key bit per cycle.
// Depends on lphash_pkg.
`default_nettype none

module lphash_mod (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  input  wire  [lphash_pkg::KEY_W-1:0] dividend,
  input  wire  [lphash_pkg::CFG_W-1:0] divisor,
  output logic                         done,
  output logic [lphash_pkg::CFG_W-1:0] rem
);
  import lphash_pkg::*;

  localparam int CNT_W = $clog2(KEY_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [KEY_W-1:0] sh_r, sh_nxt;
  logic [CFG_W-1:0] rem_r, rem_nxt;
  logic [CFG_W-1:0] div_r, div_nxt;
  logic [CFG_W:0]   trial;

  // The partial remainder stays below the divisor, so one compare and
  // subtract keeps it in range after each new bit.
  assign trial = {rem_r, sh_r[KEY_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      sh_nxt   = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = CFG_W'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = CFG_W'(trial);
      end
      sh_nxt  = {sh_r[KEY_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(KEY_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

// ===== rtl/core/linear_probe_hash_table_top.sv =====
// Top level of the linear probing hash table: control, slot memory and hashing.
// Depends on lphash_pkg, lphash_ram and lphash_mod.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one operation per transaction:
//   search, insert-or-update or remove of a 32-bit key. Every transaction
//   produces exactly one result transaction on out_valid/out_stall with
//   out_ok and out_read_value (value only on a successful search).
//   cfg_valid/cfg_ready writes table_size, the number of slots in use
//   (0 acts as 1, values above TABLE_DEPTH act as TABLE_DEPTH). Write it
//   only while no operation is outstanding.
//   Sequence: the bit-serial home slot (key modulo size) is computed first,
//   then probing reads slots from the home slot onward until the key is
//   found or every slot in use has been read, and the result is then loaded
//   into the output register. An unknown operation skips hashing and
//   probing. The next operation can be accepted once the result is loaded.
//   One operation is in flight at a time; the single memory read port sets
//   the probe rate.
//   After reset the block clears every slot's used flag, one slot per cycle,
//   with in_stall high until all slots are clear; table_size resets to 256.
//   A result waits in the output register while out_stall is high, and the
//   next operation may already be accepted and run behind it.
`default_nettype none

module linear_probe_hash_table_top #(
  parameter int TABLE_DEPTH = lphash_pkg::TABLE_DEPTH_DEF
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire  [lphash_pkg::OP_W-1:0]   in_op,
  input  wire  [lphash_pkg::KEY_W-1:0]  in_key,
  input  wire  [lphash_pkg::DATA_W-1:0] in_data,
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic                          out_ok,
  output logic [lphash_pkg::DATA_W-1:0] out_read_value,
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire  [lphash_pkg::CFG_W-1:0]  cfg_data
);
  import lphash_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam logic [CFG_W-1:0] DEPTH_CAP =
    (TABLE_DEPTH >= (1 << CFG_W)) ? {CFG_W{1'b1}} : CFG_W'(TABLE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  state_t            state_r, state_nxt;
  logic [CFG_W-1:0]  size_r;
  logic [CFG_W-1:0]  n_in_use;
  logic [CFG_W-1:0]  n_r, n_nxt;
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;
  logic [IDX_W-1:0]  clr_idx_r, clr_idx_nxt;
  logic [CFG_W-1:0]  iss_idx_r, iss_idx_nxt;
  logic [CFG_W-1:0]  iss_cnt_r, iss_cnt_nxt;
  logic              chk_vld_r, chk_vld_nxt;
  logic [CFG_W-1:0]  chk_idx_r, chk_idx_nxt;
  logic              free_found_r, free_found_nxt;
  logic [CFG_W-1:0]  free_idx_r, free_idx_nxt;
  logic              res_ok_r, res_ok_nxt;
  logic [DATA_W-1:0] res_val_r, res_val_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_ok_r, out_ok_nxt;
  logic [DATA_W-1:0] out_val_r, out_val_nxt;

  logic              in_accept;
  logic              mod_start;
  logic              mod_done;
  logic [CFG_W-1:0]  mod_rem;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  slot_t             ram_wslot;
  logic [SLOT_W-1:0] ram_rdata;
  slot_t             rd_slot;
  logic              issue;
  logic              hit;
  logic              miss_end;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign mod_start = in_accept && (in_op == OP_SEARCH || in_op == OP_INSERT ||
                                   in_op == OP_REMOVE);

  always_comb begin
    if (size_r == '0) begin
      n_in_use = CFG_W'(1);
    end else if (size_r > DEPTH_CAP) begin
      n_in_use = DEPTH_CAP;
    end else begin
      n_in_use = size_r;
    end
  end

  lphash_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (in_key),
    .divisor  (n_in_use),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  lphash_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wslot),
    .raddr (IDX_W'(iss_idx_r)),
    .rdata (ram_rdata)
  );

  assign rd_slot = slot_t'(ram_rdata);

  // Reads are issued one per cycle; the slot read last cycle is checked now.
  assign issue    = (state_r == ST_PROBE) && (iss_cnt_r < n_r);
  assign hit      = (state_r == ST_PROBE) && chk_vld_r && rd_slot.used &&
                    (rd_slot.key == key_r);
  assign miss_end = (state_r == ST_PROBE) && !chk_vld_r && (iss_cnt_r == n_r);

  always_comb begin
    state_nxt      = state_r;
    n_nxt          = n_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    data_nxt       = data_r;
    clr_idx_nxt    = clr_idx_r;
    iss_idx_nxt    = iss_idx_r;
    iss_cnt_nxt    = iss_cnt_r;
    chk_vld_nxt    = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    res_ok_nxt     = res_ok_r;
    res_val_nxt    = res_val_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_ok_nxt     = out_ok_r;
    out_val_nxt    = out_val_r;
    ram_we         = 1'b0;
    ram_waddr      = IDX_W'(chk_idx_r);
    ram_wslot      = rd_slot;

    case (state_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_idx_r;
        ram_wslot   = '0;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          op_nxt      = in_op;
          key_nxt     = in_key;
          data_nxt    = in_data;
          n_nxt       = n_in_use;
          res_ok_nxt  = 1'b0;
          res_val_nxt = '0;
          // An unknown operation touches nothing and answers a failure.
          state_nxt   = mod_start ? ST_HASH : ST_DONE;
        end
      end
      ST_HASH: begin
        if (mod_done) begin
          iss_idx_nxt    = mod_rem;
          iss_cnt_nxt    = '0;
          free_found_nxt = 1'b0;
          state_nxt      = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (issue) begin
          chk_vld_nxt = !hit;
          chk_idx_nxt = iss_idx_r;
          iss_cnt_nxt = iss_cnt_r + 1'b1;
          iss_idx_nxt = (iss_idx_r == n_r - 1'b1) ? '0 : iss_idx_r + 1'b1;
        end
        // The first free slot in probe order is where a missing key goes.
        if (chk_vld_r && !rd_slot.used && !free_found_r) begin
          free_found_nxt = 1'b1;
          free_idx_nxt   = chk_idx_r;
        end
        if (hit) begin
          state_nxt = ST_DONE;
          case (op_r)
            OP_SEARCH: begin
              res_ok_nxt  = 1'b1;
              res_val_nxt = rd_slot.value;
            end
            OP_INSERT: begin
              res_ok_nxt      = 1'b1;
              ram_we          = 1'b1;
              ram_wslot.value = data_r;
            end
            OP_REMOVE: begin
              res_ok_nxt     = 1'b1;
              ram_we         = 1'b1;
              ram_wslot.used = 1'b0;
            end
            default: begin
              res_ok_nxt = 1'b0;
            end
          endcase
        end else if (miss_end) begin
          state_nxt = ST_DONE;
          if (op_r == OP_INSERT && free_found_r) begin
            res_ok_nxt = 1'b1;
            ram_we     = 1'b1;
            ram_waddr  = IDX_W'(free_idx_r);
            ram_wslot  = '{used: 1'b1, key: key_r, value: data_r};
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_val_nxt   = res_val_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      size_r       <= CFG_SIZE_RESET;
      clr_idx_r    <= '0;
      chk_vld_r    <= 1'b0;
      iss_cnt_r    <= '0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_idx_r    <= clr_idx_nxt;
      chk_vld_r    <= chk_vld_nxt;
      iss_cnt_r    <= iss_cnt_nxt;
      free_found_r <= free_found_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        size_r <= cfg_data;
      end
    end
    n_r        <= n_nxt;
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    data_r     <= data_nxt;
    iss_idx_r  <= iss_idx_nxt;
    chk_idx_r  <= chk_idx_nxt;
    free_idx_r <= free_idx_nxt;
    res_ok_r   <= res_ok_nxt;
    res_val_r  <= res_val_nxt;
    out_ok_r   <= out_ok_nxt;
    out_val_r  <= out_val_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_read_value = out_val_r;

`ifndef SYNTHESIS
  a_write_phase : assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_CLEAR || state_r == ST_PROBE))
    else $error("slot memory written outside the clear or probe phase");

  a_probe_bound : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PROBE) |-> (iss_cnt_r <= n_r))
    else $error("probe issued more reads than slots in use");

  a_hash_done : assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> (state_r == ST_HASH))
    else $error("home slot finished while no hash was pending");

  a_accept_next : assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == ST_HASH || state_r == ST_DONE))
    else $error("accepted transaction did not start");
`endif

endmodule

`default_nettype wire
